>>> hdl/vssf_pkg.sv
`default_nettype none
package vssf_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int DIFF_BITS       = SAMPLE_BITS + 1;
  localparam int DEF_MAX_SAMPLES = 4096;
  localparam int COUNT_OUT_BITS  = 13;
  localparam int TOTAL_BITS      = 37;
  localparam int SQUARES_BITS    = 59;
  localparam int SIGMA_BITS      = 4;
  localparam int SKIP_BITS       = 8;
  localparam int CFG_DATA_BITS   = 8;
  localparam int CFG_INDEX_BITS  = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPIKE_SIGMAS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SKIP_LENGTH  = 2'd1;

  localparam logic [SIGMA_BITS-1:0] SIGMAS_RESET = 4'd7;
  localparam logic [SKIP_BITS-1:0]  SKIP_RESET   = 8'd20;

  // Magnitude of the difference of two samples, one bit wider than a sample.
  function automatic logic [DIFF_BITS-1:0] diff_mag(input logic signed [SAMPLE_BITS-1:0] a,
                                                    input logic signed [SAMPLE_BITS-1:0] b);
    logic signed [DIFF_BITS-1:0] d;
    d = DIFF_BITS'(a) - DIFF_BITS'(b);
    return d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
  endfunction

endpackage
`default_nettype wire

>>> hdl/vssf_ifs.sv
`default_nettype none
interface vssf_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [vssf_pkg::SAMPLE_BITS-1:0] sample;
  logic                                   hole;
  logic                                   last_sample;
  modport source (output valid, sample, hole, last_sample, input ready);
  modport sink   (input valid, sample, hole, last_sample, output ready);
endinterface

interface vssf_result_if;
  logic        valid;
  logic        ready;
  logic [12:0] valid_count;
  logic signed [36:0] total;
  logic [58:0] total_squares;
  logic signed [23:0] minimum;
  logic signed [23:0] maximum;
  logic [22:0] least_positive;
  logic signed [23:0] first_value;
  logic signed [23:0] final_value;
  logic [4:0]  status_bits;
  logic signed [23:0] filtered_min;
  logic signed [23:0] filtered_max;
  modport source (output valid, valid_count, total, total_squares, minimum, maximum,
                  least_positive, first_value, final_value, status_bits, filtered_min,
                  filtered_max, input ready);
  modport sink   (input valid, valid_count, total, total_squares, minimum, maximum,
                  least_positive, first_value, final_value, status_bits, filtered_min,
                  filtered_max, output ready);
endinterface
`default_nettype wire

>>> hdl/vssf_mul.sv
`default_nettype none
module vssf_mul #(
  parameter int A_BITS = 64
) (
  input  wire logic                                    clk,
  input  wire logic [A_BITS-1:0]                       a,
  input  wire logic [vssf_pkg::DIFF_BITS-1:0]          b,
  output logic      [A_BITS+vssf_pkg::DIFF_BITS-1:0]   product
);
  import vssf_pkg::*;

  // Register the product of the shared multiplier.
  always_ff @(posedge clk) begin
    product <= (A_BITS+DIFF_BITS)'(a) * (A_BITS+DIFF_BITS)'(b);
  end
endmodule
`default_nettype wire

>>> hdl/vssf_store.sv
`default_nettype none
module vssf_store #(
  parameter int DEPTH = 4096
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [$clog2(DEPTH)-1:0]               waddr,
  input  wire logic signed [vssf_pkg::SAMPLE_BITS-1:0] wvalue,
  input  wire logic                                   whole,
  input  wire logic [$clog2(DEPTH)-1:0]               raddr,
  output logic signed [vssf_pkg::SAMPLE_BITS-1:0]      rvalue,
  output logic                                        rhole
);
  import vssf_pkg::*;

  logic [SAMPLE_BITS:0] mem [DEPTH];

  // Write one entry, read one entry with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {whole, wvalue};
    end
    {rhole, rvalue} <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/vector_stats_spike_filtered_range.sv
`default_nettype none
// Vector statistics with spike-filtered range. Samples of one vector are
// taken one request at a time; each is written to an internal store, and
// each valid one is folded into count, sum, sum of squares, min, max, least
// positive value, rising flag and the sum of squared steps by one shared
// multiplier; no new sample is taken until the last is done. If a valid
// sample was seen, then after the last sample (or the one that fills the
// store) a second pass rereads the store from the first valid sample: it
// sets up the spike limit, skips holes and compares each valid sample with
// the reference; a spike whose reload index lies inside the vector reloads
// the reference. The result then waits in the output register until it is
// taken. Configuration writes take effect at once, not only for a new pass.
module vector_stats_spike_filtered_range #(
  parameter int MAX_SAMPLES = vssf_pkg::DEF_MAX_SAMPLES
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  vssf_sample_if.sink                                samples,
  vssf_result_if.source                              results,
  input  wire logic                                  cfg_we,
  input  wire logic [vssf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [vssf_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import vssf_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int MA = DIFF_BITS + CW;
  localparam int SW = MA + DIFF_BITS;
  localparam int LW = SW + 2 * SIGMA_BITS;
  localparam int PW = MA + DIFF_BITS;
  localparam int IW = CW + SKIP_BITS + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC1, S_ACC2, S_ACC3, S_LIM, S_LIMH, S_LOAD, S_READ, S_DIFF, S_SCALE,
    S_CMP, S_RELOAD, S_OUT
  } state_t;

  state_t state;

  logic [SIGMA_BITS-1:0] spike_sigmas;
  logic [SKIP_BITS-1:0]  skip_length;

  logic signed [SAMPLE_BITS-1:0] cur_value;
  logic                          cur_hole;
  logic                          cur_last;
  logic [CW-1:0]                 write_index;
  logic [CW-1:0]                 start_index;
  logic                          seen_valid;
  logic [CW-1:0]                 count_acc;
  logic signed [TOTAL_BITS-1:0]  sum_acc;
  logic [SQUARES_BITS-1:0]       square_acc;
  logic [SW-1:0]                 step_acc;
  logic signed [SAMPLE_BITS-1:0] min_reg, max_reg, pos_min, prev_value, first_valid;
  logic                          pos_found, rising;
  logic signed [SAMPLE_BITS-1:0] first_val, final_val;
  logic                          first_hole, final_hole;
  logic [LW-1:0]                 limit;
  logic signed [SAMPLE_BITS-1:0] ref_value, fmin, fmax;
  logic                          ref_hole;
  logic [IW-1:0]                 pos;

  logic [MA-1:0]         mul_a;
  logic [DIFF_BITS-1:0]  mul_b;
  logic [PW-1:0]         mul_p;
  logic [AW-1:0]         raddr;
  logic signed [SAMPLE_BITS-1:0] rvalue;
  logic                  rhole;
  logic                  accept;
  logic [IW-1:0]         len_ext, skip_pos;
  logic [DIFF_BITS-1:0]  sq_mag;
  logic [CW+COUNT_OUT_BITS-1:0] count_ext;

  assign accept   = samples.valid && samples.ready;
  assign samples.ready = (state == S_IDLE);
  assign len_ext  = IW'(write_index);
  assign skip_pos = pos + IW'(skip_length);
  assign sq_mag   = diff_mag(cur_value, '0);

  vssf_store #(.DEPTH(MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (write_index[AW-1:0]),
    .wvalue(samples.sample),
    .whole (samples.hole),
    .raddr (raddr),
    .rvalue(rvalue),
    .rhole (rhole)
  );

  vssf_mul #(.A_BITS(MA)) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .product(mul_p)
  );

  // Select multiplier operands and the store read address.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    raddr = pos[AW-1:0];
    unique case (state)
      S_ACC1: begin
        mul_a = MA'(diff_mag(cur_value, seen_valid ? prev_value : cur_value));
        mul_b = diff_mag(cur_value, seen_valid ? prev_value : cur_value);
      end
      S_ACC2: begin
        mul_a = MA'(sq_mag);
        mul_b = sq_mag;
      end
      // Limit in two halves: low part of the step sum, then the high part.
      S_LIM: begin
        mul_a = step_acc[MA-1:0];
        mul_b = DIFF_BITS'(spike_sigmas) * DIFF_BITS'(spike_sigmas);
      end
      S_LIMH: begin
        mul_a = MA'(spike_sigmas) * MA'(spike_sigmas);
        mul_b = step_acc[SW-1:MA];
      end
      // Step times count first, then times the step again.
      S_DIFF: begin
        mul_a = MA'(diff_mag(rvalue, ref_value));
        mul_b = DIFF_BITS'(count_acc);
      end
      S_SCALE: begin
        mul_a = mul_p[MA-1:0];
        mul_b = diff_mag(cur_value, ref_value);
      end
      S_CMP: raddr = skip_pos[AW-1:0];
      default: ;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      spike_sigmas <= SIGMAS_RESET;
      skip_length  <= SKIP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SPIKE_SIGMAS) spike_sigmas <= cfg_data[SIGMA_BITS-1:0];
      else if (cfg_index == REG_SKIP_LENGTH) skip_length <= cfg_data[SKIP_BITS-1:0];
    end
  end

  // Sequencer: accumulate pass, spike rejection pass, result hold.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_index <= '0;
      start_index <= '0;
      seen_valid  <= 1'b0;
      count_acc   <= '0;
      sum_acc     <= '0;
      square_acc  <= '0;
      step_acc    <= '0;
      min_reg     <= '0;
      max_reg     <= '0;
      pos_min     <= '0;
      pos_found   <= 1'b0;
      prev_value  <= '0;
      rising      <= 1'b1;
      results.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_value <= samples.sample;
            cur_hole  <= samples.hole;
            cur_last  <= samples.last_sample;
            final_val  <= samples.sample;
            final_hole <= samples.hole;
            if (write_index == '0) begin
              first_val  <= samples.sample;
              first_hole <= samples.hole;
            end
            state <= S_ACC1;
          end
        end
        S_ACC1: begin
          if (cur_hole) begin
            if (seen_valid) rising <= 1'b0;
            state <= S_ACC3;
          end else begin
            if (!seen_valid) begin
              seen_valid  <= 1'b1;
              start_index <= write_index;
              first_valid <= cur_value;
              min_reg     <= cur_value;
              max_reg     <= cur_value;
              if (write_index != '0) rising <= 1'b0;
            end else begin
              if (cur_value <= prev_value) rising <= 1'b0;
              if (cur_value > max_reg) max_reg <= cur_value;
              else if (cur_value < min_reg) min_reg <= cur_value;
            end
            if (cur_value > 0 && (!pos_found || cur_value < pos_min)) begin
              pos_min   <= cur_value;
              pos_found <= 1'b1;
            end
            prev_value <= cur_value;
            count_acc  <= count_acc + 1'b1;
            sum_acc    <= sum_acc + TOTAL_BITS'(cur_value);
            state      <= S_ACC2;
          end
        end
        S_ACC2: begin
          step_acc <= step_acc + mul_p[SW-1:0];
          state    <= S_ACC3;
        end
        S_ACC3: begin
          if (!cur_hole) square_acc <= square_acc + mul_p[SQUARES_BITS-1:0];
          write_index <= write_index + 1'b1;
          if (cur_last || (write_index == CW'(MAX_SAMPLES - 1))) begin
            fmin  <= '0;
            fmax  <= '0;
            state <= seen_valid ? S_LIM : S_OUT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_LIM: state <= S_LIMH;
        S_LIMH: begin
          limit <= LW'(mul_p);
          state <= S_LOAD;
        end
        S_LOAD: begin
          limit     <= limit + (LW'(mul_p) << MA);
          ref_value <= first_valid;
          ref_hole  <= 1'b0;
          fmin      <= first_valid;
          fmax      <= first_valid;
          pos       <= IW'(start_index);
          state     <= S_READ;
        end
        S_READ: state <= (pos < len_ext) ? S_DIFF : S_OUT;
        S_DIFF: begin
          cur_value <= rvalue;
          if (rhole) begin
            pos   <= pos + 1'b1;
            state <= S_READ;
          end else begin
            state <= S_SCALE;
          end
        end
        S_SCALE: state <= S_CMP;
        S_CMP: begin
          if (!ref_hole && (LW'(mul_p) < limit)) begin
            if (cur_value > fmax) fmax <= cur_value;
            else if (cur_value < fmin) fmin <= cur_value;
            ref_value <= cur_value;
            pos       <= pos + 1'b1;
            state     <= S_READ;
          end else begin
            // Resume past the reload point.
            pos   <= skip_pos + IW'(2);
            state <= (skip_pos < len_ext) ? S_RELOAD : S_READ;
          end
        end
        S_RELOAD: begin
          ref_value <= rvalue;
          ref_hole  <= rhole;
          state     <= S_READ;
        end
        S_OUT: begin
          if (!results.valid) begin
            results.valid <= 1'b1;
          end else if (results.ready) begin
            // Drop the result and clear for the next vector.
            results.valid <= 1'b0;
            write_index <= '0;
            start_index <= '0;
            seen_valid  <= 1'b0;
            count_acc   <= '0;
            sum_acc     <= '0;
            square_acc  <= '0;
            step_acc    <= '0;
            min_reg     <= '0;
            max_reg     <= '0;
            pos_min     <= '0;
            pos_found   <= 1'b0;
            prev_value  <= '0;
            rising      <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Drive the result payload from the held statistics.
  assign count_ext              = (CW+COUNT_OUT_BITS)'(count_acc);
  assign results.valid_count    = count_ext[COUNT_OUT_BITS-1:0];
  assign results.total          = sum_acc;
  assign results.total_squares  = square_acc;
  assign results.minimum        = min_reg;
  assign results.maximum        = max_reg;
  assign results.least_positive = pos_found ? pos_min[SAMPLE_BITS-2:0] : '0;
  assign results.first_value    = first_val;
  assign results.final_value    = final_val;
  assign results.status_bits    = {!pos_found, final_hole, first_hole, !seen_valid, rising};
  assign results.filtered_min   = fmin;
  assign results.filtered_max   = fmax;
endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import vssf_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_SAMPLES;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_HI = 2'd3;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [12:0]        valid_count;
    logic signed [36:0] total;
    logic [58:0]        total_squares;
    logic signed [23:0] minimum;
    logic signed [23:0] maximum;
    logic [22:0]        least_positive;
    logic signed [23:0] first_value;
    logic signed [23:0] final_value;
    logic [4:0]         status_bits;
    logic signed [23:0] filtered_min;
    logic signed [23:0] filtered_max;
  } vector_summary_t;

  // Vector statistics predictor plus the queue of summaries still owed by the block
  class stats_scoreboard;
    longint      store_val[STORE_DEPTH];
    bit          store_hole[STORE_DEPTH];
    int          wr_idx, first_valid_idx, n_valid;
    bit          have_valid, have_positive, rising;
    longint      acc_sum, last_valid, lo, hi, least_pos;
    logic [63:0] acc_sq, acc_step;
    int unsigned sigmas, skip;
    vector_summary_t pending[$];
    int          mismatches, summaries_checked, vectors_seen;

    function new();
      sigmas = SIGMAS_RESET;
      skip = SKIP_RESET;
      clear_vector();
    endfunction

    function void clear_vector();
      wr_idx = 0; first_valid_idx = 0; n_valid = 0;
      have_valid = 0; have_positive = 0; rising = 1;
      acc_sum = 0; acc_sq = 0; acc_step = 0;
      last_valid = 0; lo = 0; hi = 0; least_pos = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_SPIKE_SIGMAS) sigmas = data[SIGMA_BITS-1:0];
      else if (idx == REG_SKIP_LENGTH) skip = data[SKIP_BITS-1:0];
    endfunction

    // Fold one valid sample into the running statistics
    function void fold_valid(int idx, longint v);
      longint d;
      if (!have_valid) begin
        have_valid = 1;
        first_valid_idx = idx;
        lo = v; hi = v; last_valid = v;
        if (v > 0) begin
          least_pos = v; have_positive = 1;
        end
        if (idx > 0) rising = 0;
      end else if (v <= last_valid) begin
        rising = 0;
      end
      d = v - last_valid;
      acc_step += d * d;
      last_valid = v;
      n_valid++;
      acc_sum += v;
      acc_sq += v * v;
      if (v > hi) hi = v;
      else if (v < lo) lo = v;
      if (v > 0 && (!have_positive || v < least_pos)) begin
        least_pos = v; have_positive = 1;
      end
    endfunction

    // Note an accepted sample request; on end of vector, predict the summary
    function void note_sample(logic signed [23:0] s, bit h, bit l);
      int idx, len, i;
      longint v, ref_v, fmin, fmax, d;
      bit ref_hole;
      logic [79:0] limit, prod;
      vector_summary_t r;
      v = s;
      idx = (wr_idx >= STORE_DEPTH) ? STORE_DEPTH - 1 : wr_idx;
      store_val[idx] = v;
      store_hole[idx] = h;
      if (!h) fold_valid(idx, v);
      else if (have_valid) rising = 0;
      wr_idx = idx + 1;
      if (!l && wr_idx < STORE_DEPTH) return;

      len = wr_idx;
      fmin = 0; fmax = 0;
      if (have_valid) begin
        limit = 80'(acc_step) * 80'(sigmas * sigmas);
        ref_v = store_val[first_valid_idx];
        ref_hole = 0;
        fmin = ref_v; fmax = ref_v;
        i = first_valid_idx;
        while (i < len) begin
          if (store_hole[i]) begin
            i++;
          end else begin
            d = store_val[i] - ref_v;
            prod = 80'(d * d) * 80'(n_valid);
            if (!ref_hole && prod < limit) begin
              if (store_val[i] > fmax) fmax = store_val[i];
              else if (store_val[i] < fmin) fmin = store_val[i];
              ref_v = store_val[i];
              i++;
            end else begin
              // Jump the skip run, reload the reference, resume past it
              i += skip;
              if (i < len) begin
                ref_v = store_val[i];
                ref_hole = store_hole[i];
              end
              i += 2;
            end
          end
        end
      end
      r.valid_count = 13'(n_valid);
      r.total = 37'(acc_sum);
      r.total_squares = acc_sq[58:0];
      r.minimum = 24'(lo);
      r.maximum = 24'(hi);
      r.least_positive = have_positive ? 23'(least_pos) : '0;
      r.first_value = 24'(store_val[0]);
      r.final_value = 24'(store_val[len-1]);
      r.status_bits = {!have_positive, store_hole[len-1], store_hole[0], !have_valid, rising};
      r.filtered_min = 24'(fmin);
      r.filtered_max = 24'(fmax);
      pending.push_back(r);
      vectors_seen++;
      clear_vector();
    endfunction

    task flag_mismatch(string what);
      $display("mismatch @%0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_summary(vector_summary_t got);
      vector_summary_t w;
      if (pending.size() == 0) begin
        flag_mismatch("summary with none outstanding");
        return;
      end
      w = pending.pop_front();
      summaries_checked++;
      if (got.valid_count !== w.valid_count)
        flag_mismatch($sformatf("valid_count %0d exp %0d", got.valid_count, w.valid_count));
      if (got.total !== w.total)
        flag_mismatch($sformatf("total %0d exp %0d", got.total, w.total));
      if (got.total_squares !== w.total_squares)
        flag_mismatch($sformatf("total_squares %0d exp %0d", got.total_squares,
                                w.total_squares));
      if (got.minimum !== w.minimum)
        flag_mismatch($sformatf("minimum %0d exp %0d", got.minimum, w.minimum));
      if (got.maximum !== w.maximum)
        flag_mismatch($sformatf("maximum %0d exp %0d", got.maximum, w.maximum));
      if (got.least_positive !== w.least_positive)
        flag_mismatch($sformatf("least_positive %0d exp %0d", got.least_positive,
                                w.least_positive));
      if (got.first_value !== w.first_value)
        flag_mismatch($sformatf("first_value %0d exp %0d", got.first_value, w.first_value));
      if (got.final_value !== w.final_value)
        flag_mismatch($sformatf("final_value %0d exp %0d", got.final_value, w.final_value));
      if (got.status_bits !== w.status_bits)
        flag_mismatch($sformatf("status_bits %b exp %b", got.status_bits, w.status_bits));
      if (got.filtered_min !== w.filtered_min)
        flag_mismatch($sformatf("filtered_min %0d exp %0d", got.filtered_min,
                                w.filtered_min));
      if (got.filtered_max !== w.filtered_max)
        flag_mismatch($sformatf("filtered_max %0d exp %0d", got.filtered_max,
                                w.filtered_max));
    endtask
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  vssf_sample_if samples_if ();
  vssf_result_if results_if ();

  vector_stats_spike_filtered_range dut (
    .clk(clk), .rst(rst),
    .samples(samples_if.sink), .results(results_if.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  stats_scoreboard sb = new();
  int tx_idle_pct, rx_idle_pct;
  int hold_left;
  bit hold_request;
  int samples_sent;
  longint vec_val[$];
  bit vec_hole[$];

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Drive result ready: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (hold_request || hold_left > 0) begin
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 0;
      end
      hold_left--;
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check each accepted summary
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready)
      sb.check_summary('{results_if.valid_count, results_if.total, results_if.total_squares,
                         results_if.minimum, results_if.maximum, results_if.least_positive,
                         results_if.first_value, results_if.final_value,
                         results_if.status_bits, results_if.filtered_min,
                         results_if.filtered_max});
  end

  // Offer one sample request and hold it until accepted
  task send_sample(longint v, bit h, bit l);
    if ($urandom_range(99) < tx_idle_pct) begin
      samples_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.sample <= v[23:0];
    samples_if.hole <= h;
    samples_if.last_sample <= l;
    do @(posedge clk); while (!(samples_if.valid && samples_if.ready));
    sb.note_sample(samples_if.sample, samples_if.hole, samples_if.last_sample);
    samples_sent++;
  endtask

  task send_vector(bit mark_last);
    for (int i = 0; i < vec_val.size(); i++)
      send_sample(vec_val[i], vec_hole[i], mark_last && (i == vec_val.size() - 1));
    vec_val.delete();
    vec_hole.delete();
  endtask

  task add(longint v, bit h);
    vec_val.push_back(v);
    vec_hole.push_back(h);
  endtask

  // Build a random vector: mostly smooth walks with spikes and holes
  task build_vector(int len);
    int style;
    longint v;
    style = $urandom_range(99);
    v = $signed(24'($urandom)) / 4;
    for (int i = 0; i < len; i++) begin
      if (style < 15) begin
        add($signed(24'($urandom)), $urandom_range(9) == 0);
      end else if (style < 20) begin
        add(v, $urandom_range(19) == 0);
      end else if (style < 24) begin
        add($signed(24'($urandom)), 1);
      end else if (style < 30) begin
        v += $urandom_range(1, 500);
        if (v > 8388607) v = 8388607;
        add(v, 0);
      end else begin
        v += longint'($urandom_range(4000)) - 2000;
        if (v > 8000000) v = 8000000;
        if (v < -8000000) v = -8000000;
        if ($urandom_range(19) == 0)
          add(v + longint'($urandom_range(600000)) - 300000, 0);
        else
          add(v, (i < 2 && style < 40) || $urandom_range(29) == 0);
      end
    end
  endtask

  task write_cfg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  // Let the block drain before touching configuration
  task wait_drained();
    samples_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task run_random(int n_items);
    int target;
    target = samples_sent + n_items;
    while (samples_sent < target) begin
      if ($urandom_range(39) == 0) build_vector($urandom_range(100, 300));
      else build_vector($urandom_range(1, 40));
      send_vector(1);
    end
  endtask

  initial begin
    int cfg_sig[6] = '{7, 1, 15, 0, 3, 2};
    int cfg_skip[6] = '{20, 0, 255, 3, 1, 5};
    rst = 1;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    samples_if.valid = 0; samples_if.sample = '0;
    samples_if.hole = 0; samples_if.last_sample = 0;
    results_if.ready = 0;
    tx_idle_pct = 20; rx_idle_pct = 47;
    hold_left = 0; hold_request = 0; samples_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, single sample, all holes, constant, leading hole, spike, rising
    add(8388607, 0); add(-8388608, 0); add(0, 0); add(1, 0); add(-1, 0);
    send_vector(1);
    add(-8388608, 1); send_vector(1);
    add(5, 1); add(6, 1); add(7, 1); send_vector(1);
    add(42, 0); add(42, 0); add(42, 1); add(42, 0); send_vector(1);
    add(3, 1); add(-4, 0); add(10, 0); add(20, 0); send_vector(1);
    add(100, 0); add(101, 0); add(5000000, 0); add(102, 0); add(103, 0); add(104, 0);
    send_vector(1);
    add(-5, 0); add(-3, 0); add(1, 0); send_vector(1);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_cfg(REG_SPIKE_SIGMAS, 8'(cfg_sig[p]) | 8'($urandom_range(15) << 4));
      write_cfg(REG_SKIP_LENGTH, 8'(cfg_skip[p]));
      if (p == 1) write_cfg(REG_UNUSED, 8'($urandom));
      if (p == 4) write_cfg(REG_UNUSED_HI, 8'($urandom));
      tx_idle_pct = (p < 2) ? 20 : (p < 4) ? 47 : 0;
      rx_idle_pct = (p < 2) ? 47 : (p < 4) ? 20 : 0;
      if (p == 2) hold_request = 1;
      run_random(250);
      // One vector that fills the store and ends without a last mark
      if (p == 5) begin
        build_vector(STORE_DEPTH);
        send_vector(0);
      end
      wait_drained();
    end

    $display("covered %0d sample requests in %0d vectors over 6 register settings",
             samples_sent, sb.vectors_seen);
    $display("checked %0d summaries, %0d mismatches", sb.summaries_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("[vector_stats_spike_filtered_range] OK");
    else
      $display("[vector_stats_spike_filtered_range] ERROR");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout");
    $display("[vector_stats_spike_filtered_range] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
